@@ hw/rtl/disk_controller_task_file_macros.svh @@
// Assertion macros used by the checker file of the task-file controller.
// Depends on nothing; included by bare file name.
`ifndef DISK_CONTROLLER_TASK_FILE_MACROS_SVH
`define DISK_CONTROLLER_TASK_FILE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define DCTF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Property checked on every clock edge, reset included.
`define DCTF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

@@ hw/rtl/dctf_pkg.sv @@
// Package for the disk task-file controller: codes, defaults and field widths.
// Used by every module of the block.
package dctf_pkg;

   localparam int SectorBytesDefault = 512;
   localparam int DriveCountDefault  = 2;
   localparam int TrackLimitDefault  = 255;
   localparam int SectorLimitDefault = 16;

   typedef enum logic [2:0] {
      REQ_PORT_WRITE = 3'd0,
      REQ_PORT_READ  = 3'd1,
      REQ_FILL       = 3'd2,
      REQ_PULL       = 3'd3,
      REQ_DONE       = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      RSP_READ_DATA = 3'd0,
      RSP_STORE_RD  = 3'd1,
      RSP_STORE_WR  = 3'd2,
      RSP_BUF_BYTE  = 3'd3,
      RSP_LIGHT     = 3'd4
   } rsp_kind_type;

   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_RESTORE = 2'd1,
      CMD_READ    = 2'd2,
      CMD_WRITE   = 2'd3
   } cmd_type;

   localparam logic [2:0] PORT_DATA    = 3'd0;
   localparam logic [2:0] PORT_ERROR   = 3'd1;
   localparam logic [2:0] PORT_COUNT   = 3'd2;
   localparam logic [2:0] PORT_SECTOR  = 3'd3;
   localparam logic [2:0] PORT_TRK_LO  = 3'd4;
   localparam logic [2:0] PORT_TRK_HI  = 3'd5;
   localparam logic [2:0] PORT_DRVHEAD = 3'd6;
   localparam logic [2:0] PORT_CMD     = 3'd7;

   localparam logic [7:0] OP_RESTORE = 8'h10;
   localparam logic [7:0] OP_READ    = 8'h20;
   localparam logic [7:0] OP_WRITE   = 8'h30;

   localparam int ReqDataWidth = 24;
   localparam int RspDataWidth = 40;

endpackage

@@ hw/rtl/dctf_sector_buf.sv @@
// Sector buffer memory with one write port and one registered read port.
// Runs a clearing pass after reset that loads entry i with i mod 256.
module dctf_sector_buf
   import dctf_pkg::*;
#(
   parameter int SECTOR_BYTES = SectorBytesDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [$clog2(SECTOR_BYTES)-1:0] wr_addr,
   input  logic [7:0]                      wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(SECTOR_BYTES)-1:0] rd_addr,
   output logic [7:0]                      rd_data,
   output logic                            busy
);
   localparam int AW = $clog2(SECTOR_BYTES);

   logic [7:0]    mem [SECTOR_BYTES];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic          clr_busy_ff, clr_busy_in;

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == AW'(SECTOR_BYTES - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_cnt_ff] <= 8'(clr_cnt_ff);
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

@@ hw/rtl/disk_controller_task_file.sv @@
// A result is presented in the cycle after its input transfer is taken. Throughput:
// one item per cycle while no result is stalled and the buffer is not clearing; the
// task-file registers update at the input transfer and the sector buffer memory's
// read is registered. Reset: synchronous; the buffer then runs a clearing pass,
// during which no input is taken. Configuration writes are taken at any time.
module disk_controller_task_file
   import dctf_pkg::*;
#(
   parameter int SECTOR_BYTES = SectorBytesDefault,
   parameter int DRIVE_COUNT  = DriveCountDefault,
   parameter int TRACK_LIMIT  = TrackLimitDefault,
   parameter int SECTOR_LIMIT = SectorLimitDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [1:0]              csr_wr_data,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // req_tdata: port[2:0], wdata[10:3], buf_index[19:11], storage_ok[20], zero fill.
   input  logic [ReqDataWidth-1:0] req_tdata,
   // req_tuser: req_type[2:0].
   input  logic [2:0]              req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // rsp_tdata: rdata[7:0], drive[8], byte_offset[39:9].
   output logic [RspDataWidth-1:0] rsp_tdata,
   // rsp_tuser: kind[2:0].
   output logic [2:0]              rsp_tuser
);
   localparam int AW = $clog2(SECTOR_BYTES);
   localparam int PW = $clog2(SECTOR_BYTES) + 1;

   logic [2:0] in_port;
   logic [7:0] in_wdata;
   logic [8:0] in_idx;
   logic       in_ok;
   logic       accept;

   assign in_port  = req_tdata[2:0];
   assign in_wdata = req_tdata[10:3];
   assign in_idx   = req_tdata[19:11];
   assign in_ok    = req_tdata[20];

   logic [1:0]    mounted_ff;
   logic [7:0]    trk_lo_ff, trk_lo_in, trk_hi_ff, trk_hi_in;
   logic [7:0]    sec_ff, sec_in, cnt_ff, cnt_in, dh_ff, dh_in, pre_ff, pre_in;
   cmd_type       cmd_ff, cmd_in;
   logic          pend_ff, pend_in, rdy_ff, rdy_in, drq_ff, drq_in, seek_ff, seek_in;
   logic [PW-1:0] ptr_ff, ptr_in;

   logic          out_valid_ff, out_valid_in;
   rsp_kind_type  out_kind_ff, out_kind_in;
   logic [7:0]    out_rdata_ff, out_rdata_in;
   logic          out_mem_ff, out_mem_in;
   logic          out_drive_ff, out_drive_in;
   logic [30:0]   out_off_ff, out_off_in;

   logic          mem_we, mem_re, buf_busy;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata, mem_rdata;

   logic          drive, mounted, emit, ptr_ok, idx_ok;
   logic [2:0]    head;
   logic [PW-1:0] ptr_next;
   logic [30:0]   offset;

   assign drive   = (dh_ff[2:0] >= 3'd2);
   assign mounted = (32'(drive) < DRIVE_COUNT) && mounted_ff[drive];
   assign head    = drive ? (dh_ff[2:0] - 3'd2) : dh_ff[2:0];
   assign offset  = (31'({trk_hi_ff, trk_lo_ff}) << 14) + (31'(head) << 13)
                  + (31'((sec_ff == 8'd0) ? 8'd0 : (sec_ff - 8'd1)) << 9);
   assign ptr_ok  = (32'(ptr_ff) < SECTOR_BYTES);
   assign idx_ok  = (32'(in_idx) < SECTOR_BYTES);
   assign ptr_next = ptr_ff + PW'(1);

   assign req_tready = !buf_busy && (!out_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      trk_lo_in = trk_lo_ff;  trk_hi_in = trk_hi_ff;
      sec_in    = sec_ff;     cnt_in    = cnt_ff;
      dh_in     = dh_ff;      pre_in    = pre_ff;
      cmd_in    = cmd_ff;     pend_in   = pend_ff;
      rdy_in    = rdy_ff;     drq_in    = drq_ff;
      seek_in   = seek_ff;    ptr_in    = ptr_ff;
      emit         = 1'b0;
      out_kind_in  = RSP_READ_DATA;
      out_rdata_in = 8'd0;
      out_mem_in   = 1'b0;
      out_off_in   = 31'd0;
      mem_we    = 1'b0;
      mem_waddr = ptr_ff[AW-1:0];
      mem_wdata = in_wdata;
      mem_re    = 1'b0;
      mem_raddr = ptr_ff[AW-1:0];
      if (accept) begin
         case (req_tuser)
            REQ_PORT_WRITE: begin
               unique case (in_port)
                  PORT_DATA: begin
                     if (ptr_ok) begin
                        mem_we = 1'b1;
                        ptr_in = ptr_next;
                        if (32'(ptr_next) >= SECTOR_BYTES) begin
                           drq_in = 1'b0;
                           cmd_in = CMD_NONE;
                           if (cmd_ff == CMD_WRITE && mounted) begin
                              emit        = 1'b1;
                              out_kind_in = RSP_STORE_WR;
                              out_off_in  = offset;
                           end else begin
                              rdy_in = 1'b0;
                           end
                        end
                     end
                  end
                  PORT_ERROR:   pre_in    = in_wdata;
                  PORT_COUNT:   cnt_in    = in_wdata;
                  PORT_SECTOR:  sec_in    = in_wdata;
                  PORT_TRK_LO:  trk_lo_in = in_wdata;
                  PORT_TRK_HI:  trk_hi_in = in_wdata;
                  PORT_DRVHEAD: dh_in     = in_wdata;
                  default: begin
                     if (!mounted) begin
                        cmd_in  = CMD_NONE;
                        drq_in  = 1'b0;
                        seek_in = 1'b0;
                     end else begin
                        rdy_in = 1'b1;
                        if (in_wdata == OP_RESTORE) begin
                           cmd_in    = CMD_RESTORE;
                           trk_lo_in = 8'd0;
                           sec_in    = 8'd0;
                           ptr_in    = '0;
                           seek_in   = 1'b0;
                           drq_in    = 1'b0;
                        end else if (in_wdata == OP_READ) begin
                           if (32'(trk_lo_ff) > TRACK_LIMIT
                               || 32'(sec_ff) > SECTOR_LIMIT) begin
                              cmd_in = CMD_NONE;
                           end else begin
                              cmd_in      = CMD_READ;
                              rdy_in      = 1'b0;
                              pend_in     = 1'b1;
                              emit        = 1'b1;
                              out_kind_in = RSP_STORE_RD;
                              out_off_in  = offset;
                           end
                        end else if (in_wdata == OP_WRITE) begin
                           cmd_in      = CMD_WRITE;
                           ptr_in      = '0;
                           seek_in     = 1'b1;
                           drq_in      = 1'b1;
                           emit        = 1'b1;
                           out_kind_in = RSP_LIGHT;
                        end
                     end
                  end
               endcase
            end
            REQ_PORT_READ: begin
               emit        = 1'b1;
               out_kind_in = RSP_READ_DATA;
               if (!mounted) begin
                  out_rdata_in = 8'hFF;
               end else begin
                  unique case (in_port)
                     PORT_DATA: begin
                        if (ptr_ok) begin
                           mem_re     = 1'b1;
                           out_mem_in = 1'b1;
                           ptr_in     = ptr_next;
                           if (32'(ptr_next) >= SECTOR_BYTES) begin
                              drq_in = 1'b0;
                              cmd_in = CMD_NONE;
                           end
                        end
                     end
                     PORT_ERROR:   out_rdata_in = 8'h00;
                     PORT_COUNT:   out_rdata_in = cnt_ff;
                     PORT_SECTOR:  out_rdata_in = sec_ff;
                     PORT_TRK_LO:  out_rdata_in = trk_lo_ff;
                     PORT_TRK_HI:  out_rdata_in = trk_hi_ff;
                     PORT_DRVHEAD: out_rdata_in = dh_ff;
                     default:      out_rdata_in = {1'b0, rdy_ff, 1'b0, seek_ff, drq_ff, 3'b000};
                  endcase
               end
            end
            REQ_FILL: begin
               mem_we    = idx_ok;
               mem_waddr = AW'(in_idx);
            end
            REQ_PULL: begin
               emit        = 1'b1;
               out_kind_in = RSP_BUF_BYTE;
               mem_re      = idx_ok;
               mem_raddr   = AW'(in_idx);
               out_mem_in  = idx_ok;
            end
            REQ_DONE: begin
               if (pend_ff) begin
                  pend_in = 1'b0;
                  if (in_ok && cmd_ff == CMD_READ) begin
                     rdy_in      = 1'b1;
                     ptr_in      = '0;
                     seek_in     = 1'b1;
                     drq_in      = 1'b1;
                     emit        = 1'b1;
                     out_kind_in = RSP_LIGHT;
                  end else begin
                     cmd_in = CMD_NONE;
                  end
               end else if (!in_ok) begin
                  rdy_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
      out_drive_in = drive;
      if (accept) begin
         out_valid_in = emit;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mounted_ff   <= 2'd0;
         trk_lo_ff    <= 8'd0;
         trk_hi_ff    <= 8'd0;
         sec_ff       <= 8'd0;
         cnt_ff       <= 8'd0;
         dh_ff        <= 8'd0;
         pre_ff       <= 8'd0;
         cmd_ff       <= CMD_NONE;
         pend_ff      <= 1'b0;
         rdy_ff       <= 1'b1;
         drq_ff       <= 1'b0;
         seek_ff      <= 1'b0;
         ptr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mounted_ff <= csr_wr_data;
         end
         trk_lo_ff    <= trk_lo_in;
         trk_hi_ff    <= trk_hi_in;
         sec_ff       <= sec_in;
         cnt_ff       <= cnt_in;
         dh_ff        <= dh_in;
         pre_ff       <= pre_in;
         cmd_ff       <= cmd_in;
         pend_ff      <= pend_in;
         rdy_ff       <= rdy_in;
         drq_ff       <= drq_in;
         seek_ff      <= seek_in;
         ptr_ff       <= ptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // The payload only changes on an input transfer, so a stalled result holds.
   always_ff @(posedge clock) begin
      if (accept) begin
         out_kind_ff  <= out_kind_in;
         out_rdata_ff <= out_rdata_in;
         out_mem_ff   <= out_mem_in;
         out_drive_ff <= out_drive_in;
         out_off_ff   <= out_off_in;
      end
   end

   dctf_sector_buf #(
      .SECTOR_BYTES(SECTOR_BYTES)
   ) u_buf (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata),
      .busy    (buf_busy)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {out_off_ff, out_drive_ff, out_mem_ff ? mem_rdata : out_rdata_ff};

endmodule

@@ hw/rtl/dctf_checker.sv @@
// Port-level checker for the disk task-file controller, bound to the top level.
// Depends on dctf_pkg and the assertion macro header.
`include "disk_controller_task_file_macros.svh"

module dctf_checker
   import dctf_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic [2:0]              req_tuser,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata,
   input logic [2:0]              rsp_tuser
);
   // No input is taken in the cycle after reset: the buffer is being cleared.
   `DCTF_ASSERT_ALWAYS(a_clear_blocks, clock, reset |=> !req_tready)
   // Every port read transfer produces a result in the next cycle.
   `DCTF_ASSERT(a_read_answers, clock, reset, req_tvalid && req_tready && req_tuser == REQ_PORT_READ |=> rsp_tvalid)
   // Only storage requests carry a sector offset.
   `DCTF_ASSERT(a_offset_zero, clock, reset, rsp_tvalid && (rsp_tuser == RSP_READ_DATA || rsp_tuser == RSP_BUF_BYTE || rsp_tuser == RSP_LIGHT) |-> rsp_tdata[39:9] == 31'd0)
   // A stalled result stays put.
   `DCTF_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

endmodule

bind disk_controller_task_file dctf_checker u_dctf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
